// File: rtl/pwr2a_pkg.sv
// Package for the power-of-two buffer allocator.
// Shared types, FSM states and fixed field widths; no dependencies.
package pwr2a_pkg;

  // Fixed payload widths
  localparam int ADDR_W      = 17;
  localparam int SIZE_W      = 16;
  localparam int NUM_CLASSES = 9;
  localparam int TOP_CLASS   = 8;
  localparam int CLS_W       = 4;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Size class of a request; over is set when no class fits
  typedef struct packed {
    logic             over;
    logic [CLS_W-1:0] cls;
  } cls_info_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_SCAN,
    ST_CARVE,
    ST_FREE,
    ST_WSTART,
    ST_WALK,
    ST_DONE
  } alloc_state_t;

endpackage

// File: rtl/pwr2a_ram.sv
// Simple dual-port synchronous RAM with a registered read.
// Same-cycle write to the address being read is forwarded. No dependencies.
module pwr2a_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;
  logic [WIDTH-1:0] fwd_data_r;
  logic             fwd_r;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
    fwd_data_r <= wdata;
  end

  // Bypass flag for a read that collides with a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (re) begin
      fwd_r <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd_r ? fwd_data_r : rd_r;

endmodule

// File: rtl/pwr2a_size_cls.sv
// Size-class decoder: rounds a byte count up to a power-of-two class.
// Depends on pwr2a_pkg.
module pwr2a_size_cls #(
  parameter int MIN_BUFFER = 32
) (
  input  logic [pwr2a_pkg::SIZE_W-1:0] size,
  output pwr2a_pkg::cls_info_t         info
);

  logic [pwr2a_pkg::CLS_W-1:0] cnt;

  // Count the class thresholds the size exceeds
  always_comb begin
    cnt = '0;
    for (int c = 0; c < pwr2a_pkg::NUM_CLASSES; c++) begin
      if (18'(size) > 18'(MIN_BUFFER << c)) begin
        cnt = cnt + 1'b1;
      end
    end
    info.cls  = cnt;
    info.over = (cnt == pwr2a_pkg::CLS_W'(pwr2a_pkg::NUM_CLASSES));
  end

endmodule

// File: rtl/power_of_two_slab_allocator.sv
// Top level of the power-of-two buffer allocator.
// Uses pwr2a_pkg, pwr2a_size_cls and two pwr2a_ram instances (links, pages).
//
//   channel  dir  handshake            word
//   in_      in   in_valid/in_stall    kind, size_bytes, free_address
//   out_     out  out_valid/out_stall  granted_address, failed, page_released
//
// One request at a time. Pop from a list or a plain free: DECIDE, then POP or FREE, then DONE.
// Claiming a page: a scan of up to NUM_PAGES pages, then one link write per
// carved buffer, up to (PAGE_BYTES-HEADER_BYTES)/MIN_BUFFER-1.
// Releasing a page: one link-RAM read per list entry walked.
// Synchronous active-low reset empties lists and pages; no clearing pass.
// A held output word does not block the next request, only its completion.
module power_of_two_slab_allocator #(
  parameter int NUM_PAGES    = 16,
  parameter int PAGE_BYTES   = 8192,
  parameter int MIN_BUFFER   = 32,
  parameter int HEADER_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [pwr2a_pkg::SIZE_W-1:0]  in_size_bytes,
  input  logic [pwr2a_pkg::ADDR_W-1:0]  in_free_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pwr2a_pkg::ADDR_W-1:0]  out_granted_address,
  output logic                          out_failed,
  output logic                          out_page_released
);

  localparam int AW         = pwr2a_pkg::ADDR_W;
  localparam int PG_SHIFT   = $clog2(PAGE_BYTES);
  localparam int MB_SHIFT   = $clog2(MIN_BUFFER);
  localparam int LINK_DEPTH = NUM_PAGES * PAGE_BYTES / MIN_BUFFER;
  localparam int LI_W       = $clog2(LINK_DEPTH);
  localparam int PG_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FULL_FREE  = PAGE_BYTES - HEADER_BYTES;
  localparam int FB_W       = $clog2(PAGE_BYTES + 1);
  localparam int BS_W       = $clog2(MIN_BUFFER) + 9;
  localparam int OW         = ((BS_W > FB_W) ? BS_W : FB_W) + 2;
  localparam int XW         = ((LI_W > AW) ? LI_W : AW) + 1;
  localparam int ST_W       = $clog2(LINK_DEPTH + 2);
  localparam int LW         = AW + 1;
  localparam int PW         = FB_W + 1;
  localparam int NC         = pwr2a_pkg::NUM_CLASSES;
  localparam int CW         = pwr2a_pkg::CLS_W;

  // Address helpers
  function automatic logic [XW-1:0] li_full(input logic [AW-1:0] a);
    return XW'(a) >> MB_SHIFT;
  endfunction
  function automatic logic li_ok(input logic [AW-1:0] a);
    return li_full(a) < XW'(LINK_DEPTH);
  endfunction
  function automatic logic [LI_W-1:0] li_idx(input logic [AW-1:0] a);
    return li_full(a)[LI_W-1:0];
  endfunction
  function automatic logic [XW-1:0] pg_full(input logic [AW-1:0] a);
    return XW'(a) >> PG_SHIFT;
  endfunction
  function automatic logic pg_ok(input logic [AW-1:0] a);
    return pg_full(a) < XW'(NUM_PAGES);
  endfunction
  function automatic logic [PG_W-1:0] pg_idx(input logic [AW-1:0] a);
    return pg_full(a)[PG_W-1:0];
  endfunction

  localparam logic [LW-1:0] LINK_END = {1'b1, {AW{1'b0}}};

  pwr2a_pkg::alloc_state_t state_r, state_nxt;
  pwr2a_pkg::cls_info_t    info;

  logic            kind_r, kind_nxt;
  logic [CW-1:0]   cls_r, cls_nxt;
  logic            over_r, over_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [PG_W-1:0] pg_r, pg_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [LI_W-1:0] prev_r, prev_nxt;
  logic            prev_head_r, prev_head_nxt;
  logic [ST_W-1:0] steps_r, steps_nxt;
  logic [PG_W-1:0] scan_r, scan_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [OW-1:0]   off_r, off_nxt;
  logic [AW-1:0]   res_addr_r, res_addr_nxt;
  logic            res_fail_r, res_fail_nxt;
  logic            res_rel_r, res_rel_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [AW-1:0]   out_addr_r;
  logic            out_fail_r;
  logic            out_rel_r;
  logic            out_load;

  // Class heads in flops, valid bits cleared by reset
  logic [AW-1:0]   head_r [NC];
  logic [NC-1:0]   hv_r;
  logic            head_we;
  logic [AW-1:0]   head_wd;
  logic            head_wv;

  // Page claim bits
  logic [NUM_PAGES-1:0] in_use_r;
  logic                 use_we;
  logic [PG_W-1:0]      use_idx;
  logic                 use_val;

  // RAM ports
  logic            lk_re, lk_we;
  logic [LI_W-1:0] lk_raddr, lk_waddr;
  logic [LW-1:0]   lk_wdata, lk_rdata;
  logic            pp_re, pp_we;
  logic [PG_W-1:0] pp_raddr, pp_waddr;
  logic [PW-1:0]   pp_wdata, pp_rdata;

  logic [OW-1:0]   bsize;
  logic [OW-1:0]   fbw;
  logic [OW-1:0]   sum;
  logic [AW-1:0]   head_cur;
  logic            hv_cur;
  logic [AW-1:0]   carve_addr;
  logic [LW-1:0]   nxt_link;

  pwr2a_size_cls #(.MIN_BUFFER(MIN_BUFFER)) u_cls (
    .size (in_size_bytes),
    .info (info)
  );

  pwr2a_ram #(.DEPTH(LINK_DEPTH), .WIDTH(LW), .AW(LI_W)) u_link_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (lk_re),
    .raddr (lk_raddr),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .rdata (lk_rdata)
  );

  pwr2a_ram #(.DEPTH(NUM_PAGES), .WIDTH(PW), .AW(PG_W)) u_page_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (pp_re),
    .raddr (pp_raddr),
    .we    (pp_we),
    .waddr (pp_waddr),
    .wdata (pp_wdata),
    .rdata (pp_rdata)
  );

  assign bsize      = OW'(MIN_BUFFER) << cls_r;
  assign fbw        = OW'(pp_rdata[FB_W-1:0]);
  assign sum        = fbw + bsize;
  assign head_cur   = head_r[cls_r];
  assign hv_cur     = hv_r[cls_r];
  assign carve_addr = base_r + AW'(off_r);
  assign in_stall   = (state_r != pwr2a_pkg::ST_IDLE);
  assign out_load   = (state_r == pwr2a_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // Control sequencer: next state, memory ports, list and page updates
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cls_nxt       = cls_r;
    over_nxt      = over_r;
    addr_nxt      = addr_r;
    pg_nxt        = pg_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    prev_nxt      = prev_r;
    prev_head_nxt = prev_head_r;
    steps_nxt     = steps_r;
    scan_nxt      = scan_r;
    base_nxt      = base_r;
    off_nxt       = off_r;
    res_addr_nxt  = res_addr_r;
    res_fail_nxt  = res_fail_r;
    res_rel_nxt   = res_rel_r;
    out_valid_nxt = out_valid_r && out_stall;
    head_we  = 1'b0;
    head_wd  = head_cur;
    head_wv  = hv_cur;
    use_we   = 1'b0;
    use_idx  = pg_r;
    use_val  = 1'b0;
    lk_re    = 1'b0;
    lk_raddr = li_idx(cur_r);
    lk_we    = 1'b0;
    lk_waddr = li_idx(addr_r);
    lk_wdata = LINK_END;
    pp_re    = 1'b0;
    pp_raddr = pg_idx(addr_r);
    pp_we    = 1'b0;
    pp_waddr = pg_r;
    pp_wdata = pp_rdata;
    nxt_link = lk_rdata;

    case (state_r)
      pwr2a_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          cls_nxt   = info.cls;
          over_nxt  = info.over;
          addr_nxt  = in_free_address;
          state_nxt = pwr2a_pkg::ST_DECIDE;
        end
      end

      pwr2a_pkg::ST_DECIDE: begin
        res_addr_nxt = '0;
        res_fail_nxt = 1'b0;
        res_rel_nxt  = 1'b0;
        if (over_r) begin
          res_fail_nxt = 1'b1;
          state_nxt    = pwr2a_pkg::ST_DONE;
        end else if (kind_r == pwr2a_pkg::KIND_ALLOC) begin
          if (hv_cur) begin
            // pop the head: fetch its link and its page record
            cur_nxt   = head_cur;
            lk_re     = li_ok(head_cur);
            lk_raddr  = li_idx(head_cur);
            pp_re     = 1'b1;
            pp_raddr  = pg_idx(head_cur);
            state_nxt = pwr2a_pkg::ST_POP;
          end else begin
            scan_nxt  = '0;
            state_nxt = pwr2a_pkg::ST_SCAN;
          end
        end else begin
          pg_nxt = pg_idx(addr_r);
          if (pg_ok(addr_r) && in_use_r[pg_idx(addr_r)]) begin
            pp_re     = 1'b1;
            state_nxt = pwr2a_pkg::ST_FREE;
          end else begin
            state_nxt = pwr2a_pkg::ST_DONE;
          end
        end
      end

      pwr2a_pkg::ST_POP: begin
        nxt_link = li_ok(cur_r) ? lk_rdata : LINK_END;
        head_we  = 1'b1;
        head_wv  = !nxt_link[LW-1];
        head_wd  = nxt_link[AW-1:0];
        if (pg_ok(cur_r) && in_use_r[pg_idx(cur_r)]) begin
          pp_we    = 1'b1;
          pp_waddr = pg_idx(cur_r);
          pp_wdata = {pp_rdata[PW-1], (fbw > bsize) ? FB_W'(fbw - bsize) : FB_W'(0)};
        end
        res_addr_nxt = cur_r;
        state_nxt    = pwr2a_pkg::ST_DONE;
      end

      // Lowest free page, one page per cycle
      pwr2a_pkg::ST_SCAN: begin
        if (!in_use_r[scan_r]) begin
          use_we       = 1'b1;
          use_idx      = scan_r;
          use_val      = 1'b1;
          base_nxt     = AW'({scan_r, {PG_SHIFT{1'b0}}});
          res_addr_nxt = AW'({scan_r, {PG_SHIFT{1'b0}}}) + AW'(HEADER_BYTES);
          pp_we        = 1'b1;
          pp_waddr     = scan_r;
          off_nxt      = OW'(HEADER_BYTES) + bsize;
          state_nxt    = pwr2a_pkg::ST_DONE;
          if (cls_r == CW'(pwr2a_pkg::TOP_CLASS)) begin
            pp_wdata = {1'b1, FB_W'(0)};
          end else begin
            pp_wdata = {1'b0, (OW'(FULL_FREE) > bsize) ? FB_W'(OW'(FULL_FREE) - bsize)
                                                       : FB_W'(0)};
            if (OW'(HEADER_BYTES) + (bsize << 1) <= OW'(PAGE_BYTES)) begin
              // second buffer becomes the list head
              head_we   = 1'b1;
              head_wv   = 1'b1;
              head_wd   = AW'({scan_r, {PG_SHIFT{1'b0}}}) + AW'(OW'(HEADER_BYTES) + bsize);
              state_nxt = pwr2a_pkg::ST_CARVE;
            end
          end
        end else if (scan_r == PG_W'(NUM_PAGES - 1)) begin
          res_fail_nxt = 1'b1;
          state_nxt    = pwr2a_pkg::ST_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // Chain the remaining buffers in ascending order, one link a cycle
      pwr2a_pkg::ST_CARVE: begin
        lk_we    = 1'b1;
        lk_waddr = li_idx(carve_addr);
        off_nxt  = off_r + bsize;
        if (off_r + (bsize << 1) <= OW'(PAGE_BYTES)) begin
          lk_wdata = {1'b0, carve_addr + AW'(bsize)};
        end else begin
          lk_wdata  = LINK_END;
          state_nxt = pwr2a_pkg::ST_DONE;
        end
      end

      pwr2a_pkg::ST_FREE: begin
        state_nxt = pwr2a_pkg::ST_DONE;
        if (cls_r == CW'(pwr2a_pkg::TOP_CLASS)) begin
          if (pp_rdata[PW-1]) begin
            use_we      = 1'b1;
            res_rel_nxt = 1'b1;
          end
        end else if (!pp_rdata[PW-1]) begin
          if (sum >= OW'(FULL_FREE)) begin
            cur_nxt       = head_cur;
            cur_valid_nxt = hv_cur;
            prev_head_nxt = 1'b1;
            state_nxt     = pwr2a_pkg::ST_WSTART;
          end else begin
            pp_we    = 1'b1;
            pp_wdata = {1'b0, FB_W'(sum)};
            lk_we    = 1'b1;
            lk_wdata = hv_cur ? {1'b0, head_cur} : LINK_END;
            head_we  = 1'b1;
            head_wv  = 1'b1;
            head_wd  = addr_r;
          end
        end
      end

      pwr2a_pkg::ST_WSTART: begin
        if (cur_valid_r && li_ok(cur_r)) begin
          lk_re     = 1'b1;
          steps_nxt = ST_W'(1);
          state_nxt = pwr2a_pkg::ST_WALK;
        end else begin
          use_we      = 1'b1;
          res_rel_nxt = 1'b1;
          state_nxt   = pwr2a_pkg::ST_DONE;
        end
      end

      // Unlink every entry of the released page; next read overlaps the splice
      pwr2a_pkg::ST_WALK: begin
        if (pg_full(cur_r) == XW'(pg_r)) begin
          if (prev_head_r) begin
            head_we = 1'b1;
            head_wv = !nxt_link[LW-1];
            head_wd = nxt_link[AW-1:0];
          end else begin
            lk_we    = 1'b1;
            lk_waddr = prev_r;
            lk_wdata = nxt_link;
          end
        end else begin
          prev_nxt      = li_idx(cur_r);
          prev_head_nxt = 1'b0;
        end
        cur_nxt       = nxt_link[AW-1:0];
        cur_valid_nxt = !nxt_link[LW-1];
        if (!nxt_link[LW-1] && (steps_r <= ST_W'(LINK_DEPTH))
            && li_ok(nxt_link[AW-1:0])) begin
          lk_re     = 1'b1;
          lk_raddr  = li_idx(nxt_link[AW-1:0]);
          steps_nxt = steps_r + 1'b1;
        end else begin
          use_we      = 1'b1;
          res_rel_nxt = 1'b1;
          state_nxt   = pwr2a_pkg::ST_DONE;
        end
      end

      pwr2a_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = pwr2a_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pwr2a_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwr2a_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      hv_r        <= '0;
      in_use_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        hv_r[cls_r] <= head_wv;
      end
      if (use_we) begin
        in_use_r[use_idx] <= use_val;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    cls_r       <= cls_nxt;
    over_r      <= over_nxt;
    addr_r      <= addr_nxt;
    pg_r        <= pg_nxt;
    cur_r       <= cur_nxt;
    cur_valid_r <= cur_valid_nxt;
    prev_r      <= prev_nxt;
    prev_head_r <= prev_head_nxt;
    steps_r     <= steps_nxt;
    scan_r      <= scan_nxt;
    base_r      <= base_nxt;
    off_r       <= off_nxt;
    res_addr_r  <= res_addr_nxt;
    res_fail_r  <= res_fail_nxt;
    res_rel_r   <= res_rel_nxt;
    if (head_we) begin
      head_r[cls_r] <= head_wd;
    end
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_fail_r <= res_fail_r;
      out_rel_r  <= res_rel_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_failed          = out_fail_r;
  assign out_page_released   = out_rel_r;

  // Checks
  a_fail_rel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_failed && out_page_released))
    else $error("failed and page_released both set");

  a_rel_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pwr2a_pkg::ST_DONE && res_rel_r) |-> kind_r == pwr2a_pkg::KIND_FREE)
    else $error("page released by an allocation");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pwr2a_pkg::ST_WALK |-> steps_r <= ST_W'(LINK_DEPTH + 1))
    else $error("list walk overran its step bound");

  a_carve_class: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pwr2a_pkg::ST_CARVE |-> cls_r != CW'(pwr2a_pkg::TOP_CLASS))
    else $error("whole-page class carved into buffers");

endmodule
